// ===== rtl/core/btp_pkg.sv =====
// Shared types, constants and helpers for the brush texture paint blend pipeline.
package btp_pkg;

    localparam int TEX_WIDTH_LOG2_DEF  = 8;
    localparam int TEX_HEIGHT_LOG2_DEF = 8;
    localparam int CANVAS_MAX_LOG2_DEF = 12;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int CANVAS_REG_W = 13;
    localparam int PIX_W        = 12;
    localparam int FACTOR_W     = 16;
    localparam int COORD_W      = 32;
    localparam int COLOR_W      = 8;
    localparam int TEXEL_W      = 24;
    localparam int TEX_AW       = 16;
    localparam int TEX_DEPTH    = 65536;

    // Quotient bits of the three division steps
    localparam int WORLD_QW = 31;
    localparam int RATIO_QW = 16;
    localparam int TILE_QW  = 8;

    localparam logic [16:0]  UNIT_Q16    = 17'h10000;
    localparam logic [7:0]   ALPHA_FULL  = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CANVAS_WIDTH   = 3'd0,
        REG_CANVAS_HEIGHT  = 3'd1,
        REG_WORLD_SIZE     = 3'd2,
        REG_BRUSH_X        = 3'd3,
        REG_BRUSH_Z        = 3'd4,
        REG_BRUSH_RADIUS   = 3'd5,
        REG_BRUSH_OPACITY  = 3'd6,
        REG_TEXTURE_TILING = 3'd7
    } cfg_reg_t;

    localparam logic [CANVAS_REG_W-1:0] RST_CANVAS_WIDTH   = 13'd512;
    localparam logic [CANVAS_REG_W-1:0] RST_CANVAS_HEIGHT  = 13'd512;
    localparam logic [COORD_W-1:0]      RST_WORLD_SIZE     = 32'd65536;
    localparam logic [COORD_W-1:0]      RST_BRUSH_X        = 32'd0;
    localparam logic [COORD_W-1:0]      RST_BRUSH_Z        = 32'd0;
    localparam logic [COORD_W-1:0]      RST_BRUSH_RADIUS   = 32'd65536;
    localparam logic [FACTOR_W-1:0]     RST_BRUSH_OPACITY  = 16'd256;
    localparam logic [FACTOR_W-1:0]     RST_TEXTURE_TILING = 16'd256;

    typedef struct packed {
        logic               func;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] dest_red;
        logic [COLOR_W-1:0] dest_green;
        logic [COLOR_W-1:0] dest_blue;
        logic [TEX_AW-1:0]  texel_index;
        logic [COLOR_W-1:0] texel_red;
        logic [COLOR_W-1:0] texel_green;
        logic [COLOR_W-1:0] texel_blue;
    } req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic [COLOR_W-1:0] out_alpha;
        logic               painted;
    } rsp_t;

    // Per-item data that rides alongside the arithmetic
    typedef struct packed {
        logic               paint;
        logic               skip;
        logic               sgn_x;
        logic               sgn_z;
        logic [COLOR_W-1:0] dest_red;
        logic [COLOR_W-1:0] dest_green;
        logic [COLOR_W-1:0] dest_blue;
        logic [TEXEL_W-1:0] texel;
        logic [TEX_AW-1:0]  addr;
    } side_t;

    // floor((d*65536 + (c-d)*a) / 65536); the result lies between d and c
    function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] d,
                                                 input logic [COLOR_W-1:0] c,
                                                 input logic [16:0] a);
        logic signed [9:0]  diff;
        logic signed [27:0] prod;
        logic signed [27:0] acc;
        diff = $signed({2'b00, c}) - $signed({2'b00, d});
        prod = 28'(diff * $signed({1'b0, a}));
        acc  = $signed({4'b0000, d, 16'h0000}) + prod;
        return acc[23:16];
    endfunction

endpackage

// ===== rtl/core/brush_texture_paint_blend.sv =====
// Top level: brush falloff, tiled texture lookup and color blend pipeline.
//
//  port group   direction  handshake            payload
//  cfg          in         cfg_we               cfg_addr, cfg_wdata
//  req          in         req_valid/req_ready  req (btp_pkg::req_t)
//  rsp          out        rsp_valid/rsp_ready  rsp (btp_pkg::rsp_t)
//
// One transaction per cycle while the skid register is empty. A paint
// result passes through the 31-step world-position divider and the 16-step
// falloff-ratio divider. Load transactions flow through the same stages
// and write the texture RAM at the stage where paints read. Reset loads the
// register defaults and clears all valid bits; the texture RAM is not
// cleared. A result held at the output goes to a skid register, and the
// whole pipeline holds while that register is full.
module brush_texture_paint_blend #(
    parameter int TEX_WIDTH_LOG2  = btp_pkg::TEX_WIDTH_LOG2_DEF,
    parameter int TEX_HEIGHT_LOG2 = btp_pkg::TEX_HEIGHT_LOG2_DEF,
    parameter int CANVAS_MAX_LOG2 = btp_pkg::CANVAS_MAX_LOG2_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [btp_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [btp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  btp_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output btp_pkg::rsp_t                    rsp
);

    localparam int DIM_W   = CANVAS_MAX_LOG2 + 1;
    localparam int CMP_W   = (DIM_W > btp_pkg::CANVAS_REG_W) ? DIM_W : btp_pkg::CANVAS_REG_W;
    localparam int XC_W    = (DIM_W > btp_pkg::PIX_W) ? DIM_W : btp_pkg::PIX_W;
    localparam int OX_W    = DIM_W + 2;
    localparam int WN_W    = DIM_W + btp_pkg::COORD_W;
    localparam int WD_W    = DIM_W + 1;
    localparam int TD_W    = DIM_W + btp_pkg::TILE_QW;
    localparam int TN1_W   = btp_pkg::PIX_W + btp_pkg::FACTOR_W;
    localparam int TEX_L   = (TEX_WIDTH_LOG2 > TEX_HEIGHT_LOG2) ? TEX_WIDTH_LOG2
                                                                : TEX_HEIGHT_LOG2;
    localparam int TN2_W   = TD_W + TEX_L;
    localparam int TFULL_W = TEX_WIDTH_LOG2 + TEX_HEIGHT_LOG2;
    localparam int SIDE_W  = $bits(btp_pkg::side_t);

    localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(1) << CANVAS_MAX_LOG2;

    // Stage numbers: register stage that holds each item's values
    localparam int WORLD_LAT = btp_pkg::WORLD_QW + 1;
    localparam int TEX_LAT   = (btp_pkg::TILE_QW + 1) + (TEX_L + 1);
    localparam int RATIO_LAT = btp_pkg::RATIO_QW + 1;
    localparam int S_PREP    = 2;
    localparam int S_WORLD   = S_PREP + WORLD_LAT;
    localparam int S_TEX     = S_PREP + TEX_LAT;
    localparam int TEX_DLY   = S_WORLD - S_TEX;
    localparam int S_DX      = S_WORLD + 1;
    localparam int S_ABS     = S_DX + 1;
    localparam int S_SQ      = S_ABS + 1;
    localparam int S_SUM     = S_SQ + 1;
    localparam int S_RATIO   = S_SUM + RATIO_LAT;
    localparam int S_K       = S_RATIO + 1;
    localparam int S_F       = S_K + 1;
    localparam int S_A       = S_F + 1;
    localparam int S_RD      = S_A + 1;
    localparam int S_OUT     = S_RD + 1;

    // Configuration registers
    logic [btp_pkg::CANVAS_REG_W-1:0] canvas_width_reg, canvas_height_reg;
    logic [btp_pkg::COORD_W-1:0]      world_size_reg, brush_x_reg, brush_z_reg;
    logic [btp_pkg::COORD_W-1:0]      brush_radius_reg;
    logic [btp_pkg::FACTOR_W-1:0]     brush_opacity_reg, texture_tiling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg   <= btp_pkg::RST_CANVAS_WIDTH;
            canvas_height_reg  <= btp_pkg::RST_CANVAS_HEIGHT;
            world_size_reg     <= btp_pkg::RST_WORLD_SIZE;
            brush_x_reg        <= btp_pkg::RST_BRUSH_X;
            brush_z_reg        <= btp_pkg::RST_BRUSH_Z;
            brush_radius_reg   <= btp_pkg::RST_BRUSH_RADIUS;
            brush_opacity_reg  <= btp_pkg::RST_BRUSH_OPACITY;
            texture_tiling_reg <= btp_pkg::RST_TEXTURE_TILING;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                btp_pkg::REG_CANVAS_WIDTH:
                    canvas_width_reg <= cfg_wdata[btp_pkg::CANVAS_REG_W-1:0];
                btp_pkg::REG_CANVAS_HEIGHT:
                    canvas_height_reg <= cfg_wdata[btp_pkg::CANVAS_REG_W-1:0];
                btp_pkg::REG_WORLD_SIZE:     world_size_reg   <= cfg_wdata;
                btp_pkg::REG_BRUSH_X:        brush_x_reg      <= cfg_wdata;
                btp_pkg::REG_BRUSH_Z:        brush_z_reg      <= cfg_wdata;
                btp_pkg::REG_BRUSH_RADIUS:   brush_radius_reg <= cfg_wdata;
                btp_pkg::REG_BRUSH_OPACITY:
                    brush_opacity_reg <= cfg_wdata[btp_pkg::FACTOR_W-1:0];
                btp_pkg::REG_TEXTURE_TILING:
                    texture_tiling_reg <= cfg_wdata[btp_pkg::FACTOR_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Effective canvas size: zero acts as one, clamp to the maximum
    logic [CMP_W-1:0] cw_ext, ch_ext;
    logic [DIM_W-1:0] eff_w, eff_h;

    always_comb
    begin
        cw_ext = CMP_W'(canvas_width_reg);
        ch_ext = CMP_W'(canvas_height_reg);
        if (cw_ext == '0)
            eff_w = DIM_W'(1);
        else if (cw_ext > DIM_MAX)
            eff_w = DIM_W'(DIM_MAX);
        else
            eff_w = DIM_W'(cw_ext);
        if (ch_ext == '0)
            eff_h = DIM_W'(1);
        else if (ch_ext > DIM_MAX)
            eff_h = DIM_W'(DIM_MAX);
        else
            eff_h = DIM_W'(ch_ext);
    end

    logic [2*btp_pkg::COORD_W-1:0] r2_reg;

    always_ff @(posedge clk)
    begin
        r2_reg <= brush_radius_reg * brush_radius_reg;
    end

    // Pipeline control
    logic              adv;
    logic              skid_valid_reg;
    logic [S_OUT:1]    vld_reg;

    assign adv       = !skid_valid_reg;
    assign req_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[S_OUT-1:1], req_valid};
        end
    end

    // Stage 1: input register
    btp_pkg::req_t req_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req_reg <= req;
        end
    end

    logic                    x_in, y_in;
    logic signed [OX_W-1:0]  ox_x, ox_z;
    logic [DIM_W-1:0]        mag_x, mag_z;
    logic [TN1_W-1:0]        pt_x, pt_z;
    btp_pkg::side_t          side1;

    always_comb
    begin
        x_in  = XC_W'(req_reg.pixel_x) < XC_W'(eff_w);
        y_in  = XC_W'(req_reg.pixel_y) < XC_W'(eff_h);
        ox_x  = $signed(OX_W'({req_reg.pixel_x, 1'b0})) - $signed(OX_W'(eff_w));
        ox_z  = $signed(OX_W'({req_reg.pixel_y, 1'b0})) - $signed(OX_W'(eff_h));
        mag_x = DIM_W'(ox_x[OX_W-1] ? -ox_x : ox_x);
        mag_z = DIM_W'(ox_z[OX_W-1] ? -ox_z : ox_z);
        pt_x  = TN1_W'(req_reg.pixel_x) * TN1_W'(texture_tiling_reg);
        pt_z  = TN1_W'(req_reg.pixel_y) * TN1_W'(texture_tiling_reg);

        side1.paint      = req_reg.func;
        side1.skip       = !x_in || !y_in || (world_size_reg == '0)
                           || (brush_radius_reg == '0);
        side1.sgn_x      = ox_x[OX_W-1];
        side1.sgn_z      = ox_z[OX_W-1];
        side1.dest_red   = req_reg.dest_red;
        side1.dest_green = req_reg.dest_green;
        side1.dest_blue  = req_reg.dest_blue;
        side1.texel      = {req_reg.texel_red, req_reg.texel_green, req_reg.texel_blue};
        side1.addr       = req_reg.texel_index;
    end

    // Stage 2: operands for the dividers
    logic [DIM_W-1:0] mag_x2_reg, mag_z2_reg;
    logic [TN1_W-1:0] pt_x2_reg, pt_z2_reg;
    btp_pkg::side_t   side2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_x2_reg <= mag_x;
            mag_z2_reg <= mag_z;
            pt_x2_reg  <= pt_x;
            pt_z2_reg  <= pt_z;
            side2_reg  <= side1;
        end
    end

    // World position magnitude: |2p - W| * world_size / (2W)
    logic [WN_W-1:0]             wnum_x, wnum_z;
    logic [btp_pkg::WORLD_QW-1:0] wq_x, wq_z;

    assign wnum_x = WN_W'(mag_x2_reg) * WN_W'(world_size_reg);
    assign wnum_z = WN_W'(mag_z2_reg) * WN_W'(world_size_reg);

    btp_div_pipe #(.NUM_W(WN_W), .DEN_W(WD_W), .Q_W(btp_pkg::WORLD_QW)) u_wdiv_x (
        .clk (clk), .en (adv), .num (wnum_x), .den ({eff_w, 1'b0}),
        .quo (wq_x), .rem ()
    );

    btp_div_pipe #(.NUM_W(WN_W), .DEN_W(WD_W), .Q_W(btp_pkg::WORLD_QW)) u_wdiv_z (
        .clk (clk), .en (adv), .num (wnum_z), .den ({eff_h, 1'b0}),
        .quo (wq_z), .rem ()
    );

    // Texel coordinates: fraction of p*T/(256*dim), then its top bits
    logic [TD_W-1:0]  tn_x, tn_z;
    logic [TEX_L-1:0] tq_x, tq_z;
    logic [TFULL_W-1:0]        tex_full;
    logic [btp_pkg::TEX_AW-1:0] tex_addr, tex_addr_w;

    btp_div_pipe #(.NUM_W(TN1_W), .DEN_W(TD_W), .Q_W(btp_pkg::TILE_QW)) u_tmod_x (
        .clk (clk), .en (adv), .num (pt_x2_reg),
        .den ({eff_w, {btp_pkg::TILE_QW{1'b0}}}), .quo (), .rem (tn_x)
    );

    btp_div_pipe #(.NUM_W(TN1_W), .DEN_W(TD_W), .Q_W(btp_pkg::TILE_QW)) u_tmod_z (
        .clk (clk), .en (adv), .num (pt_z2_reg),
        .den ({eff_h, {btp_pkg::TILE_QW{1'b0}}}), .quo (), .rem (tn_z)
    );

    btp_div_pipe #(.NUM_W(TN2_W), .DEN_W(TD_W), .Q_W(TEX_L)) u_tfrac_x (
        .clk (clk), .en (adv), .num ({tn_x, {TEX_L{1'b0}}}),
        .den ({eff_w, {btp_pkg::TILE_QW{1'b0}}}), .quo (tq_x), .rem ()
    );

    btp_div_pipe #(.NUM_W(TN2_W), .DEN_W(TD_W), .Q_W(TEX_L)) u_tfrac_z (
        .clk (clk), .en (adv), .num ({tn_z, {TEX_L{1'b0}}}),
        .den ({eff_h, {btp_pkg::TILE_QW{1'b0}}}), .quo (tq_z), .rem ()
    );

    assign tex_full = {tq_z[TEX_L-1 -: TEX_HEIGHT_LOG2], tq_x[TEX_L-1 -: TEX_WIDTH_LOG2]};
    assign tex_addr = btp_pkg::TEX_AW'(tex_full);

    btp_delay #(.WIDTH(btp_pkg::TEX_AW), .DEPTH(TEX_DLY)) u_tex_dly (
        .clk (clk), .en (adv), .d (tex_addr), .q (tex_addr_w)
    );

    btp_pkg::side_t side_w;

    btp_delay #(.WIDTH(SIDE_W), .DEPTH(WORLD_LAT)) u_side_w_dly (
        .clk (clk), .en (adv), .d (side2_reg), .q (side_w)
    );

    // Offset from the brush center
    logic signed [33:0] pos_x, pos_z;
    logic signed [33:0] dx_reg, dz_reg;
    btp_pkg::side_t     side_dx, side_dx_reg;

    always_comb
    begin
        pos_x = side_w.sgn_x ? -$signed({3'b000, wq_x}) : $signed({3'b000, wq_x});
        pos_z = side_w.sgn_z ? -$signed({3'b000, wq_z}) : $signed({3'b000, wq_z});
        side_dx = side_w;
        side_dx.addr = side_w.paint ? tex_addr_w : side_w.addr;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg      <= pos_x - $signed({{2{brush_x_reg[31]}}, brush_x_reg});
            dz_reg      <= pos_z - $signed({{2{brush_z_reg[31]}}, brush_z_reg});
            side_dx_reg <= side_dx;
        end
    end

    // Absolute offsets and the square box test
    logic signed [33:0] abs_x, abs_z;
    logic               far_xz;
    logic [31:0]        adx_reg, adz_reg;
    btp_pkg::side_t     side_abs, side_abs_reg;

    always_comb
    begin
        abs_x  = dx_reg[33] ? -dx_reg : dx_reg;
        abs_z  = dz_reg[33] ? -dz_reg : dz_reg;
        far_xz = (abs_x[32:0] >= {1'b0, brush_radius_reg})
                 || (abs_z[32:0] >= {1'b0, brush_radius_reg});
        side_abs = side_dx_reg;
        side_abs.skip = side_dx_reg.skip || far_xz;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            adx_reg      <= abs_x[31:0];
            adz_reg      <= abs_z[31:0];
            side_abs_reg <= side_abs;
        end
    end

    // Squares
    logic [63:0]    sqx_reg, sqz_reg;
    btp_pkg::side_t side_sq_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg     <= adx_reg * adx_reg;
            sqz_reg     <= adz_reg * adz_reg;
            side_sq_reg <= side_abs_reg;
        end
    end

    // Squared distance against squared radius
    logic [64:0]    s2_sum;
    logic [63:0]    s2_reg;
    btp_pkg::side_t side_sum, side_sum_reg;

    always_comb
    begin
        s2_sum = {1'b0, sqx_reg} + {1'b0, sqz_reg};
        side_sum = side_sq_reg;
        side_sum.skip = side_sq_reg.skip || (s2_sum >= {1'b0, r2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg       <= s2_sum[63:0];
            side_sum_reg <= side_sum;
        end
    end

    // Ratio (d/r)^2 in Q0.16
    logic [btp_pkg::RATIO_QW-1:0] ratio_q;
    btp_pkg::side_t               side_q;

    btp_div_pipe #(.NUM_W(64 + btp_pkg::RATIO_QW), .DEN_W(64), .Q_W(btp_pkg::RATIO_QW))
    u_ratio_div (
        .clk (clk), .en (adv), .num ({s2_reg, {btp_pkg::RATIO_QW{1'b0}}}),
        .den (r2_reg), .quo (ratio_q), .rem ()
    );

    btp_delay #(.WIDTH(SIDE_W), .DEPTH(RATIO_LAT)) u_side_q_dly (
        .clk (clk), .en (adv), .d (side_sum_reg), .q (side_q)
    );

    // Falloff and opacity
    logic [16:0]    k_reg, f_reg, a_reg, a_rd_reg;
    logic [33:0]    kk;
    logic [32:0]    fo;
    logic [24:0]    fo_sc;
    btp_pkg::side_t side_k_reg, side_f_reg, side_a, side_a_reg, side_rd_reg;

    always_comb
    begin
        kk    = k_reg * k_reg;
        fo    = f_reg * brush_opacity_reg;
        fo_sc = fo[32:8];
        side_a = side_f_reg;
        side_a.skip = side_f_reg.skip || (f_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_reg      <= btp_pkg::UNIT_Q16 - {1'b0, ratio_q};
            side_k_reg <= side_q;
            f_reg      <= kk[32:16];
            side_f_reg <= side_k_reg;
            a_reg      <= (fo_sc > 25'(btp_pkg::UNIT_Q16)) ? btp_pkg::UNIT_Q16 : fo_sc[16:0];
            side_a_reg <= side_a;
            a_rd_reg    <= a_reg;
            side_rd_reg <= side_a_reg;
        end
    end

    // Texture store: loads write and paints read at the same stage
    logic                         ram_we;
    logic [btp_pkg::TEXEL_W-1:0]  texel_rd;

    assign ram_we = adv && vld_reg[S_A] && !side_a_reg.paint;

    btp_ram #(.WIDTH(btp_pkg::TEXEL_W), .DEPTH(btp_pkg::TEX_DEPTH)) u_tex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (side_a_reg.addr),
        .wdata (side_a_reg.texel),
        .re    (adv),
        .raddr (side_a_reg.addr),
        .rdata (texel_rd)
    );

    // Blend into the result register
    btp_pkg::rsp_t res, res_reg;
    logic          paint_out_reg;

    always_comb
    begin
        if (side_rd_reg.skip)
        begin
            res.out_red   = side_rd_reg.dest_red;
            res.out_green = side_rd_reg.dest_green;
            res.out_blue  = side_rd_reg.dest_blue;
            res.out_alpha = '0;
            res.painted   = 1'b0;
        end
        else
        begin
            res.out_red   = btp_pkg::blend(side_rd_reg.dest_red, texel_rd[23:16], a_rd_reg);
            res.out_green = btp_pkg::blend(side_rd_reg.dest_green, texel_rd[15:8], a_rd_reg);
            res.out_blue  = btp_pkg::blend(side_rd_reg.dest_blue, texel_rd[7:0], a_rd_reg);
            res.out_alpha = btp_pkg::ALPHA_FULL;
            res.painted   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg       <= res;
            paint_out_reg <= side_rd_reg.paint;
        end
    end

    // Output register with skid stage
    logic          last_valid;
    logic          rsp_valid_reg;
    btp_pkg::rsp_t rsp_reg, skid_reg;

    assign last_valid = vld_reg[S_OUT] && paint_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (rsp_ready)
            begin
                rsp_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (last_valid)
        begin
            if (!rsp_valid_reg || rsp_ready)
                rsp_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (rsp_ready)
                rsp_reg <= skid_reg;
        end
        else if (last_valid)
        begin
            if (!rsp_valid_reg || rsp_ready)
                rsp_reg <= res_reg;
            else
                skid_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The skid register fills only behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> rsp_valid_reg)
        else $error("skid holds a transaction while the output is empty");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
        else $error("pipeline stalled without a blocked output");

    a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[S_OUT] && !adv) |=> vld_reg[S_OUT])
        else $error("last stage lost its transaction during a stall");

    a_ram_write_moves: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (vld_reg[S_A] && adv))
        else $error("texture write without an advancing load");

endmodule

// ===== rtl/core/btp_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module btp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/btp_delay.sv =====
// Enabled shift line that keeps side data aligned with a long arithmetic path.
module btp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ===== rtl/core/btp_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage; needs num >> Q_W < den.
module btp_div_pipe #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int Q_W   = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo,
    output logic [DEN_W-1:0] rem
);

    logic [DEN_W-1:0] rem_reg [Q_W+1];
    logic [Q_W-1:0]   quo_reg [Q_W+1];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(num >> Q_W);
            low_reg[0] <= num[Q_W-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < Q_W; i++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           fits;

        always_comb
        begin
            trial = {rem_reg[i], low_reg[i][Q_W-1]};
            fits  = (trial >= {1'b0, den_reg[i]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= fits ? DEN_W'(trial - {1'b0, den_reg[i]})
                                     : trial[DEN_W-1:0];
                quo_reg[i+1] <= (quo_reg[i] << 1) | Q_W'(fits);
            end
        end

        if (i + 1 < Q_W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    low_reg[i+1] <= low_reg[i] << 1;
                    den_reg[i+1] <= den_reg[i];
                end
            end
        end
    end

    assign quo = quo_reg[Q_W];
    assign rem = rem_reg[Q_W];

endmodule

// ===== verif/brush_paint_checker.sv =====
// Checker for the brush paint blend unit: tracks registers and texels, predicts and compares.
`timescale 1ns / 1ps

module brush_paint_checker
    import btp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  req_t                  req,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  rsp_t                  rsp,
    output int                    errors,
    output int                    pending
);

    localparam int TEX_WL   = TEX_WIDTH_LOG2_DEF;
    localparam int TEX_HL   = TEX_HEIGHT_LOG2_DEF;
    localparam int DIM_MAX  = 1 << CANVAS_MAX_LOG2_DEF;

    logic [12:0] cur_width, cur_height;
    logic [31:0] cur_world, cur_bx, cur_bz, cur_radius;
    logic [15:0] cur_opacity, cur_tiling;
    logic [23:0] texels [TEX_DEPTH];
    rsp_t        expected_pixels [$];

    function automatic longint unsigned clamp_dim(logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_MAX)
            return DIM_MAX;
        return v;
    endfunction

    function automatic longint world_coord(longint unsigned p, longint unsigned dim);
        longint num;
        num = (2 * longint'(p) - longint'(dim)) * longint'({32'd0, cur_world});
        return num / (2 * longint'(dim));
    endfunction

    function automatic longint unsigned tile_coord(longint unsigned p, longint unsigned dim,
                                                   int lg);
        longint unsigned den, n;
        den = 256 * dim;
        n = (p * cur_tiling) % den;
        return (n << lg) / den;
    endfunction

    function automatic logic [7:0] mix_channel(logic [7:0] d, logic [7:0] c,
                                               longint unsigned a);
        longint t;
        t = longint'(d) * 65536 + (longint'(c) - longint'(d)) * longint'(a);
        return t[23:16];
    endfunction

    function automatic rsp_t paint_result(req_t it);
        rsp_t            r;
        longint unsigned w, h, rad, r2, s2, rem, q, adx, adz, k, f, a, tx, ty;
        longint          dx, dz;
        logic            top;
        logic [23:0]     tex;
        r = '{out_red: it.dest_red, out_green: it.dest_green, out_blue: it.dest_blue,
              out_alpha: 8'd0, painted: 1'b0};
        w = clamp_dim(cur_width);
        h = clamp_dim(cur_height);
        rad = cur_radius;
        if (it.pixel_x >= w || it.pixel_y >= h || cur_world == 0 || rad == 0)
            return r;
        dx = world_coord(it.pixel_x, w) - longint'($signed(cur_bx));
        dz = world_coord(it.pixel_y, h) - longint'($signed(cur_bz));
        adx = dx < 0 ? -dx : dx;
        adz = dz < 0 ? -dz : dz;
        if (adx >= rad || adz >= rad)
            return r;
        r2 = rad * rad;
        s2 = adx * adx + adz * adz;
        if (s2 < adx * adx || s2 >= r2)
            return r;
        rem = s2;
        q = 0;
        for (int i = 0; i < 16; i++)
        begin
            top = rem[63];
            rem = rem << 1;
            q = q << 1;
            if (top || rem >= r2)
            begin
                rem = rem - r2;
                q = q | 1;
            end
        end
        k = 65536 - q;
        f = (k * k) >> 16;
        if (f == 0)
            return r;
        a = (f * cur_opacity) >> 8;
        if (a > 65536)
            a = 65536;
        tx = tile_coord(it.pixel_x, w, TEX_WL);
        ty = tile_coord(it.pixel_y, h, TEX_HL);
        tex = texels[16'((ty << TEX_WL) | tx)];
        r.out_red   = mix_channel(it.dest_red, tex[23:16], a);
        r.out_green = mix_channel(it.dest_green, tex[15:8], a);
        r.out_blue  = mix_channel(it.dest_blue, tex[7:0], a);
        r.out_alpha = ALPHA_FULL;
        r.painted   = 1'b1;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_width   <= RST_CANVAS_WIDTH;
            cur_height  <= RST_CANVAS_HEIGHT;
            cur_world   <= RST_WORLD_SIZE;
            cur_bx      <= RST_BRUSH_X;
            cur_bz      <= RST_BRUSH_Z;
            cur_radius  <= RST_BRUSH_RADIUS;
            cur_opacity <= RST_BRUSH_OPACITY;
            cur_tiling  <= RST_TEXTURE_TILING;
            expected_pixels.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_CANVAS_WIDTH:   cur_width   <= cfg_wdata[12:0];
                    REG_CANVAS_HEIGHT:  cur_height  <= cfg_wdata[12:0];
                    REG_WORLD_SIZE:     cur_world   <= cfg_wdata;
                    REG_BRUSH_X:        cur_bx      <= cfg_wdata;
                    REG_BRUSH_Z:        cur_bz      <= cfg_wdata;
                    REG_BRUSH_RADIUS:   cur_radius  <= cfg_wdata;
                    REG_BRUSH_OPACITY:  cur_opacity <= cfg_wdata[15:0];
                    REG_TEXTURE_TILING: cur_tiling  <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
            begin
                if (req.func)
                    expected_pixels.push_back(paint_result(req));
                else
                    texels[req.texel_index] = {req.texel_red, req.texel_green, req.texel_blue};
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result transaction %h", rsp);
                    errors <= errors + 1;
                end
                else
                begin
                    rsp_t e;
                    int   bad;
                    e = expected_pixels.pop_front();
                    bad = 0;
                    if (rsp.out_red !== e.out_red)
                    begin
                        $error("out_red expected %0d actual %0d", e.out_red, rsp.out_red);
                        bad++;
                    end
                    if (rsp.out_green !== e.out_green)
                    begin
                        $error("out_green expected %0d actual %0d", e.out_green, rsp.out_green);
                        bad++;
                    end
                    if (rsp.out_blue !== e.out_blue)
                    begin
                        $error("out_blue expected %0d actual %0d", e.out_blue, rsp.out_blue);
                        bad++;
                    end
                    if (rsp.out_alpha !== e.out_alpha)
                    begin
                        $error("out_alpha expected %0d actual %0d", e.out_alpha, rsp.out_alpha);
                        bad++;
                    end
                    if (rsp.painted !== e.painted)
                    begin
                        $error("painted expected %0d actual %0d", e.painted, rsp.painted);
                        bad++;
                    end
                    errors <= errors + bad;
                end
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the brush paint blend testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import btp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 80;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    int                    errors, pending;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    cycles = 0;
    int                    canvas_w = 512, canvas_h = 512;

    always #5 clk = ~clk;

    brush_texture_paint_blend dut (.*);

    brush_paint_checker checker_i (.*);

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send(req_t item);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        forever
        begin
            @(negedge clk);
            rdy = req_ready;
            @(posedge clk);
            if (rdy)
                break;
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CANVAS_WIDTH)
            canvas_w = val[12:0] == 0 ? 1 : (val[12:0] > 4096 ? 4096 : val[12:0]);
        if (idx == REG_CANVAS_HEIGHT)
            canvas_h = val[12:0] == 0 ? 1 : (val[12:0] > 4096 ? 4096 : val[12:0]);
    endtask

    task automatic load_texel(logic [15:0] idx);
        req_t it;
        it = req_t'({$urandom, $urandom, $urandom, $urandom});
        it.func = 1'b0;
        it.texel_index = idx;
        send(it);
    endtask

    task automatic paint(int x, int y, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        req_t it;
        it = req_t'({$urandom, $urandom, $urandom, $urandom});
        it.func = 1'b1;
        it.pixel_x = x;
        it.pixel_y = y;
        it.dest_red = r;
        it.dest_green = g;
        it.dest_blue = b;
        send(it);
    endtask

    task automatic random_paint();
        int x, y;
        if ($urandom_range(9) == 0)
        begin
            x = $urandom_range(4095);
            y = $urandom_range(4095);
        end
        else
        begin
            x = $urandom_range(canvas_w - 1);
            y = $urandom_range(canvas_h - 1);
        end
        paint(x, y, $urandom, $urandom, $urandom);
    endtask

    task automatic random_settings();
        logic [31:0] ws, rad;
        longint      bx, bz;
        if ($urandom_range(3) == 0)
        begin
            write_reg(REG_CANVAS_WIDTH, $urandom_range(0, 8191));
            write_reg(REG_CANVAS_HEIGHT, $urandom_range(0, 8191));
        end
        else
        begin
            write_reg(REG_CANVAS_WIDTH, $urandom_range(1, 64));
            write_reg(REG_CANVAS_HEIGHT, $urandom_range(1, 64));
        end
        ws = ($urandom_range(7) == 0) ? $urandom : ($urandom_range(1, 64) << 16);
        write_reg(REG_WORLD_SIZE, ws);
        bx = longint'($urandom_range(0, ws)) - longint'(ws / 2);
        bz = longint'($urandom_range(0, ws)) - longint'(ws / 2);
        write_reg(REG_BRUSH_X, 32'(bx));
        write_reg(REG_BRUSH_Z, 32'(bz));
        rad = ($urandom_range(7) == 0) ? $urandom : ws / 4 + $urandom_range(1, ws / 2 + 1);
        write_reg(REG_BRUSH_RADIUS, rad);
        write_reg(REG_BRUSH_OPACITY,
                  ($urandom_range(5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1024));
        write_reg(REG_TEXTURE_TILING, $urandom_range(0, 65535));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole texture store so every paint reads a written texel.
        for (int i = 0; i < TEX_DEPTH; i++)
            load_texel(i);

        // Directed: reset settings, center, edges and out-of-canvas pixels.
        paint(256, 256, 8'd0, 8'd255, 8'd0);
        paint(255, 257, 8'd255, 8'd0, 8'd255);
        paint(0, 0, 8'd0, 8'd0, 8'd0);
        paint(511, 511, 8'd255, 8'd255, 8'd255);
        paint(512, 10, 8'd12, 8'd34, 8'd56);
        paint(4095, 4095, 8'd1, 8'd2, 8'd3);
        drain();
        // Zero opacity, then full opacity clamp with tiling extremes.
        write_reg(REG_BRUSH_OPACITY, 16'd0);
        write_reg(REG_TEXTURE_TILING, 16'd0);
        paint(256, 256, 8'd100, 8'd150, 8'd200);
        paint(250, 260, 8'd100, 8'd150, 8'd200);
        drain();
        write_reg(REG_BRUSH_OPACITY, 16'hFFFF);
        write_reg(REG_TEXTURE_TILING, 16'hFFFF);
        paint(300, 200, 8'd9, 8'd90, 8'd190);
        paint(256, 256, 8'd255, 8'd0, 8'd128);
        drain();
        // Zero world size and zero radius.
        write_reg(REG_WORLD_SIZE, 32'd0);
        paint(256, 256, 8'd7, 8'd8, 8'd9);
        drain();
        write_reg(REG_WORLD_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_BRUSH_RADIUS, 32'd0);
        paint(256, 256, 8'd7, 8'd8, 8'd9);
        drain();
        // Huge radius, brush at extreme coordinates, canvas of 0 and oversize.
        write_reg(REG_BRUSH_RADIUS, 32'hFFFF_FFFF);
        write_reg(REG_BRUSH_X, 32'h8000_0000);
        write_reg(REG_BRUSH_Z, 32'h7FFF_FFFF);
        write_reg(REG_CANVAS_WIDTH, 13'd0);
        write_reg(REG_CANVAS_HEIGHT, 13'h1FFF);
        paint(0, 0, 8'd50, 8'd60, 8'd70);
        paint(0, 4095, 8'd50, 8'd60, 8'd70);
        paint(1, 2048, 8'd50, 8'd60, 8'd70);
        drain();
        // Small radius: a row of pixels from the brush center out past the rim.
        write_reg(REG_CANVAS_WIDTH, 13'd4096);
        write_reg(REG_CANVAS_HEIGHT, 13'd4096);
        write_reg(REG_WORLD_SIZE, 32'd65536);
        write_reg(REG_BRUSH_X, 32'd0);
        write_reg(REG_BRUSH_Z, 32'd0);
        write_reg(REG_BRUSH_RADIUS, 32'd40);
        write_reg(REG_BRUSH_OPACITY, 16'd256);
        for (int i = 0; i < 4; i++)
            paint(2048 + i, 2048, $urandom, $urandom, $urandom);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            random_settings();
            for (int i = 0; i < 62; i++)
            begin
                if (ph == 2 && i == 30)
                begin
                    // Hold off until every outstanding pixel has returned.
                    req_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
                if ($urandom_range(4) == 0)
                    load_texel($urandom);
                else
                    random_paint();
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
